@@ rtl/iva_pkg.sv @@
// ----------------------------------------------------------------------------
// iva_pkg
// Shared widths, operation codes and types for the integer 3-vector ALU.
// ----------------------------------------------------------------------------
package iva_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int OUT_WIDTH  = 2 * COMP_WIDTH + 2;
  localparam int PROD_WIDTH = 2 * COMP_WIDTH;
  localparam int KIND_WIDTH = 3;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_DOT   = 3'd2,
    KIND_CROSS = 3'd3,
    KIND_MAG2  = 3'd4,
    KIND_NORM  = 3'd5
  } kind_t;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [OUT_WIDTH-1:0]  res_t;

endpackage

@@ rtl/iva_if.sv @@
// ----------------------------------------------------------------------------
// iva_in_if / iva_out_if
// Valid/ready channels carrying operand beats and result beats.
// ----------------------------------------------------------------------------
interface iva_in_if
  import iva_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [KIND_WIDTH-1:0] kind;
  comp_t                 a_x;
  comp_t                 a_y;
  comp_t                 a_z;
  comp_t                 b_x;
  comp_t                 b_y;
  comp_t                 b_z;

  modport source (output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface iva_out_if
  import iva_pkg::*;
  ();
  logic valid;
  logic ready;
  res_t res_x;
  res_t res_y;
  res_t res_z;
  res_t res_scalar;

  modport source (output valid, res_x, res_y, res_z, res_scalar, input ready);
  modport sink (input valid, res_x, res_y, res_z, res_scalar, output ready);
endinterface

@@ rtl/int_vec3_alu_core.sv @@
// ----------------------------------------------------------------------------
// int_vec3_alu_core
// Four-stage pipelined integer 3-vector ALU: add, subtract, dot, cross,
// squared magnitude and normalize.
// ----------------------------------------------------------------------------
// The core accepts one beat per cycle unless the output stalls, and returns each
// result via an input register, a multiplier stage, an adder stage and a select
// stage that feeds the output register. The whole pipeline advances together
// whenever the output register is empty or its beat is being taken, so a
// downstream stall freezes every stage and nothing is lost or repeated.
// Normalize never needs an explicit square root: with f the floor square root
// of |A|^2, each quotient a/f is the sign of a when |a| + 1 squared exceeds
// |A|^2 and zero otherwise. A zero vector and unused codes give zero results.
module int_vec3_alu_core
  import iva_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  iva_in_if.sink    din,
  iva_out_if.source dout
);

  localparam int AW = COMP_WIDTH + 1;

  logic adv;

  // Stage 1: registered operands.
  logic              v1;
  logic [KIND_WIDTH-1:0] kind1;
  comp_t             ax1, ay1, az1, bx1, by1, bz1;
  logic [AW-1:0]     qx1, qy1, qz1;

  // Stage 2: products.
  logic              v2;
  logic [KIND_WIDTH-1:0] kind2;
  logic signed [PROD_WIDTH-1:0] p_xx, p_yy, p_zz;
  logic signed [PROD_WIDTH-1:0] p_ybz, p_zby, p_zbx, p_xbz, p_xby, p_ybx;
  logic signed [PROD_WIDTH-1:0] s_xx, s_yy, s_zz;
  logic [2*AW-1:0]   q2x, q2y, q2z;
  comp_t             ax2, ay2, az2, bx2, by2, bz2;

  // Stage 3: sums.
  logic              v3;
  logic [KIND_WIDTH-1:0] kind3;
  res_t              add_x, add_y, add_z, sub_x, sub_y, sub_z;
  res_t              crs_x, crs_y, crs_z, dot3, mag3;
  logic [2*AW-1:0]   q3x, q3y, q3z;
  logic              nx3, ny3, nz3;

  // Stage 4: output register.
  logic              v4;
  res_t              rx, ry, rz, rs;
  res_t              rx_next, ry_next, rz_next, rs_next;

  assign adv        = !v4 || dout.ready;
  assign din.ready  = adv;
  assign dout.valid = v4;
  assign dout.res_x = rx;
  assign dout.res_y = ry;
  assign dout.res_z = rz;
  assign dout.res_scalar = rs;

  function automatic logic [AW-1:0] abs_plus1(comp_t c);
    logic signed [AW-1:0] e;
    logic        [AW-1:0] m;
    e = AW'(c);
    m = (e < 0) ? AW'(-e) : AW'(e);
    return m + AW'(1);
  endfunction

  function automatic res_t sgn(comp_t c);
    if (c == '0) begin
      return '0;
    end else if (c < 0) begin
      return -res_t'(1);
    end else begin
      return res_t'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1 <= din.kind;
      ax1 <= din.a_x; ay1 <= din.a_y; az1 <= din.a_z;
      bx1 <= din.b_x; by1 <= din.b_y; bz1 <= din.b_z;
      qx1 <= abs_plus1(din.a_x);
      qy1 <= abs_plus1(din.a_y);
      qz1 <= abs_plus1(din.a_z);

      kind2 <= kind1;
      p_xx  <= ax1 * bx1;  p_yy  <= ay1 * by1;  p_zz  <= az1 * bz1;
      p_ybz <= ay1 * bz1;  p_zby <= az1 * by1;
      p_zbx <= az1 * bx1;  p_xbz <= ax1 * bz1;
      p_xby <= ax1 * by1;  p_ybx <= ay1 * bx1;
      s_xx  <= ax1 * ax1;  s_yy  <= ay1 * ay1;  s_zz  <= az1 * az1;
      q2x   <= (2*AW)'(qx1) * (2*AW)'(qx1);
      q2y   <= (2*AW)'(qy1) * (2*AW)'(qy1);
      q2z   <= (2*AW)'(qz1) * (2*AW)'(qz1);
      ax2 <= ax1; ay2 <= ay1; az2 <= az1;
      bx2 <= bx1; by2 <= by1; bz2 <= bz1;

      kind3 <= kind2;
      add_x <= res_t'(ax2) + res_t'(bx2);
      add_y <= res_t'(ay2) + res_t'(by2);
      add_z <= res_t'(az2) + res_t'(bz2);
      sub_x <= res_t'(ax2) - res_t'(bx2);
      sub_y <= res_t'(ay2) - res_t'(by2);
      sub_z <= res_t'(az2) - res_t'(bz2);
      crs_x <= res_t'(p_ybz) - res_t'(p_zby);
      crs_y <= res_t'(p_zbx) - res_t'(p_xbz);
      crs_z <= res_t'(p_xby) - res_t'(p_ybx);
      dot3  <= res_t'(p_xx) + res_t'(p_yy) + res_t'(p_zz);
      mag3  <= res_t'(s_xx) + res_t'(s_yy) + res_t'(s_zz);
      q3x <= q2x; q3y <= q2y; q3z <= q2z;
      // Only a nonzero component can give a nonzero normalized quotient.
      nx3 <= (ax2 != '0);
      ny3 <= (ay2 != '0);
      nz3 <= (az2 != '0);

      rx <= rx_next; ry <= ry_next; rz <= rz_next; rs <= rs_next;
    end
  end

  // Sign of each A component, carried beside the sums.
  comp_t sx3, sy3, sz3;
  always_ff @(posedge clk) begin
    if (adv) begin
      sx3 <= ax2[COMP_WIDTH-1] ? -comp_t'(1) : comp_t'(1);
      sy3 <= ay2[COMP_WIDTH-1] ? -comp_t'(1) : comp_t'(1);
      sz3 <= az2[COMP_WIDTH-1] ? -comp_t'(1) : comp_t'(1);
    end
  end

  always_comb begin
    logic [OUT_WIDTH-1:0] m;
    rx_next = '0;
    ry_next = '0;
    rz_next = '0;
    rs_next = '0;
    m = mag3;
    case (kind3)
      KIND_ADD: begin
        rx_next = add_x; ry_next = add_y; rz_next = add_z;
      end
      KIND_SUB: begin
        rx_next = sub_x; ry_next = sub_y; rz_next = sub_z;
      end
      KIND_DOT: begin
        rs_next = dot3;
      end
      KIND_CROSS: begin
        rx_next = crs_x; ry_next = crs_y; rz_next = crs_z;
      end
      KIND_MAG2: begin
        rs_next = mag3;
      end
      KIND_NORM: begin
        if (nx3 && (2*AW)'(m) < q3x) rx_next = sgn(sx3);
        if (ny3 && (2*AW)'(m) < q3y) ry_next = sgn(sy3);
        if (nz3 && (2*AW)'(m) < q3z) rz_next = sgn(sz3);
      end
      default: begin
      end
    endcase
  end

endmodule
